// File: design/mipmap_box_filter_chain_defines.svh
// assertion helpers for the mip chain top file
`ifndef MIPMAP_BOX_FILTER_CHAIN_DEFINES_SVH
`define MIPMAP_BOX_FILTER_CHAIN_DEFINES_SVH

// property checked on every clock outside reset
`define MBFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// trigger in one cycle, consequence in the next
`define MBFC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mbfc_pkg.sv
package mbfc_pkg;

    localparam int LEVEL_W    = 4;
    localparam int POS_W      = 10;
    localparam int CH_W       = 8;
    localparam int LANES      = 4;
    localparam int SIZE_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = LANES * CH_W;
    localparam int M_TDATA_W  = LEVEL_W + 2 * POS_W + LANES * CH_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIP_MODE  = 2'd1;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd8;
    localparam logic [MODE_W-1:0] MIP_MODE_RST  = MODE_AVG;

    // lane 0 is red, then green, blue, alpha
    typedef logic [LANES-1:0][CH_W-1:0] pix_t;
    typedef logic [LANES-1:0][CH_W:0]   pair_t;
    typedef logic [LANES-1:0][CH_W+1:0] quad_t;

    typedef struct packed {
        logic valid;
        pix_t pix;
    } pix_tok_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        pix_t             pix;
    } cell_out_t;

    typedef struct packed {
        pix_t               pix;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } res_t;

endpackage

// File: design/mipmap_box_filter_chain.sv
// Streaming mip generator: RGBA pixels of a square 2^size_log2 image enter in raster order
// (red in the low byte) and every lower level down to 1x1 leaves as results carrying level,
// column, row and the 2x2 filtered channels; tlast marks the last result a pixel causes.
// Each level is one cell of a chain that keeps its raster counters, the pending left pixel
// and a row buffer of even-row pair sums, so a result reaches the next level in the next
// clock. A pixel that completes no 2x2 block is taken every clock; a pixel that completes
// more than one level holds off the next pixel while its cascade walks the chain. Results
// drain through a 32-entry queue (for the default depth), and a pixel is taken only while
// the queue has room for a full cascade. A write to either register restarts the frame at
// pixel (0,0). In mode none no results leave.
`include "mipmap_box_filter_chain_defines.svh"

module mipmap_box_filter_chain #(
    parameter int MAX_SIDE_LOG2 = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbfc_pkg::S_TDATA_W-1:0]  s_tdata,   // red, green, blue, alpha
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbfc_pkg::M_TDATA_W-1:0]  m_tdata,   // level, col, row, out_red,
                                                       // out_green, out_blue, out_alpha
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbfc_pkg::*;

    localparam int N          = MAX_SIDE_LOG2;
    localparam int FIFO_DEPTH = 1 << $clog2(2 * (N + 1));
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADMIT_MAX  = FIFO_DEPTH - N - 1;
    localparam int SIZE_RST_I = (N < int'(SIZE_LOG2_RST)) ? N : int'(SIZE_LOG2_RST);

    logic [SIZE_W-1:0] size_log2_reg;
    logic [MODE_W-1:0] mip_mode_reg;
    logic [SIZE_W-1:0] size_wr;
    logic              cfg_fire;
    logic              restart;
    logic              s_fire;
    logic              sum_mode;

    pix_tok_t  cell_in  [N];
    cell_out_t cell_out [N];
    logic [N-1:0] armed;
    logic [N-1:0] live;
    logic [N-1:0] res_vec;
    logic         any_live;

    res_t             res;
    res_t             out_res;
    logic             push;
    logic [CNT_W-1:0] fifo_count;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index inside {REG_SIZE_LOG2, REG_MIP_MODE});
    assign size_wr   = (cfg_data[SIZE_W-1:0] > SIZE_W'(N)) ? SIZE_W'(N)
                                                          : cfg_data[SIZE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= SIZE_W'(SIZE_RST_I);
            mip_mode_reg  <= MIP_MODE_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_SIZE_LOG2: size_log2_reg <= size_wr;
                REG_MIP_MODE:  mip_mode_reg  <= cfg_data[MODE_W-1:0];
                default:       ;
            endcase
        end
    end

    assign sum_mode = mip_mode_reg == MODE_SUM;
    assign s_fire   = s_tvalid && s_tready;

    // a token that will still produce a result keeps new pixels out of the chain
    assign any_live = |live;
    assign s_tready = !any_live && (fifo_count <= CNT_W'(ADMIT_MAX));

    assign cell_in[0].valid = s_fire && (mip_mode_reg != MODE_NONE);
    assign cell_in[0].pix   = pix_t'(s_tdata);

    for (genvar l = 0; l < N; l++) begin : g_cell
        if (l > 0) begin : g_link
            assign cell_in[l].valid = cell_out[l-1].valid;
            assign cell_in[l].pix   = cell_out[l-1].pix;
        end

        mbfc_cell #(
            .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
            .LEVEL         (l)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .restart   (restart),
            .size_log2 (size_log2_reg),
            .sum_mode  (sum_mode),
            .in_tok    (cell_in[l]),
            .out_tok   (cell_out[l]),
            .armed     (armed[l])
        );

        assign res_vec[l] = cell_out[l].valid;
        if (l < N - 1) begin : g_live
            assign live[l] = cell_out[l].valid && armed[l+1];
        end else begin : g_top
            assign live[l] = 1'b0;
        end
    end

    // at most one cell holds a fresh result in any cycle
    always_comb begin
        res = '0;
        for (int l = 0; l < N; l++) begin
            if (res_vec[l]) begin
                res.level = LEVEL_W'(l + 1);
                res.col   = cell_out[l].col;
                res.row   = cell_out[l].row;
                res.pix   = cell_out[l].pix;
                res.last  = !live[l];
            end
        end
    end

    assign push = |res_vec;

    mbfc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_res),
        .count     (fifo_count)
    );

    assign m_tdata = {out_res.pix, out_res.row, out_res.col, out_res.level};
    assign m_tlast = out_res.last;

    `MBFC_ASSERT(a_one_result, $onehot0(res_vec), "two levels finished in one cycle")
    `MBFC_ASSERT(a_no_overflow, !(push && fifo_count == CNT_W'(FIFO_DEPTH)), "queue overflow")
    `MBFC_ASSERT_NEXT(a_restart_flush, restart, res_vec == '0, "result left after restart")

endmodule

// File: design/mbfc_cell.sv
module mbfc_cell #(
    parameter int MAX_SIDE_LOG2 = 11,
    parameter int LEVEL         = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  logic [mbfc_pkg::SIZE_W-1:0] size_log2,
    input  logic                        sum_mode,
    input  mbfc_pkg::pix_tok_t          in_tok,
    output mbfc_pkg::cell_out_t         out_tok,
    output logic                        armed
);
    import mbfc_pkg::*;

    localparam int CW    = MAX_SIDE_LOG2 - LEVEL;
    localparam int DEPTH = 1 << (CW - 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          active;
    logic          take;
    logic          last_col;
    logic [CW-1:0] side_mask;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    pix_t          held_reg;
    pair_t         pair;
    pair_t         rd_reg;
    quad_t         total;
    pix_t          filt;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic          prod;

    logic             out_valid_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [POS_W-1:0] out_row_reg;
    pix_t             out_pix_reg;

    // even-row pair sums of this level, one entry per output column
    pair_t row_sum_mem [1 << AW];

    always_comb begin
        for (int b = 0; b < CW; b++) begin
            side_mask[b] = int'(size_log2) > LEVEL + b;
        end
    end

    assign active   = int'(size_log2) > LEVEL;
    assign take     = in_tok.valid && active;
    assign last_col = col_reg == side_mask;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (take) begin
            if (last_col) begin
                col_next = '0;
                row_next = (row_reg == side_mask) ? '0 : CW'(row_reg + 1'b1);
            end else begin
                col_next = CW'(col_reg + 1'b1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            pair[k]  = {1'b0, held_reg[k]} + {1'b0, in_tok.pix[k]};
            total[k] = {1'b0, rd_reg[k]} + {1'b0, pair[k]};
            filt[k]  = sum_mode ? total[k][CH_W-1:0] : total[k][CH_W+1:2];
        end
    end

    assign wr_en   = take && col_reg[0] && !row_reg[0];
    assign prod    = take && col_reg[0] && row_reg[0];
    assign wr_addr = AW'(col_reg >> 1);
    // prefetch the entry that the next pixel of this level will need
    assign rd_addr = AW'(col_next >> 1);
    assign armed   = active && col_reg[0] && row_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !col_reg[0]) begin
            held_reg <= in_tok.pix;
        end
        if (prod) begin
            out_col_reg <= POS_W'(col_reg >> 1);
            out_row_reg <= POS_W'(row_reg >> 1);
            out_pix_reg <= filt;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_sum_mem[wr_addr] <= pair;
        end
        rd_reg <= row_sum_mem[rd_addr];
    end

    always_comb begin
        out_tok.valid = out_valid_reg;
        out_tok.col   = out_col_reg;
        out_tok.row   = out_row_reg;
        out_tok.pix   = out_pix_reg;
    end

endmodule

// File: design/mbfc_out_fifo.sv
module mbfc_out_fifo #(
    parameter int DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  mbfc_pkg::res_t               push_data,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output mbfc_pkg::res_t               pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import mbfc_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    res_t fifo_mem [DEPTH];

    assign pop = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = count_reg != '0;
    assign pop_data  = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mbfc_pkg::*;

    localparam int MAX_SIDE     = 11;
    localparam int PAIR_ROWS    = (1 << MAX_SIDE) - 1;
    localparam int SETTLE_CYC   = 64;
    localparam int HOLD_CYC     = 600;
    localparam int CYCLE_LIMIT  = 400000;

    // indexes past the register list, the block must drop them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    // top mode code behaves like the average
    localparam logic [MODE_W-1:0] MODE_AVG_ALT = 2'd3;

    typedef enum logic {DO_WRITE, DO_PIXEL} step_kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        pix_t               pix;
        logic               last;
    } mip_pixel_t;

    // m_tdata from the top bit down, level sits in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0]    alpha;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [LEVEL_W-1:0] level;
    } m_word_t;

    typedef struct packed {
        step_kind_t              kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        pix_t                    pix;
        logic                    typed;
        mip_pixel_t              want;
    } step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the block
    int unsigned cur_size;
    logic [MODE_W-1:0] cur_mode;
    quad_t       pair_row [PAIR_ROWS];
    quad_t       held_left [MAX_SIDE];
    int unsigned col_cnt [MAX_SIDE + 1];
    int unsigned row_cnt [MAX_SIDE + 1];

    mip_pixel_t owed_mips[$];
    int         err_count = 0;
    int         cycle_count = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_toggle = 1'b0;
    logic       hold_seen = 1'b0;
    int         hold_left = 0;

    mipmap_box_filter_chain u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic quad_t lane_sum(input quad_t a, input quad_t b);
        quad_t r;
        for (int k = 0; k < LANES; k++)
            r[k] = a[k] + b[k];
        return r;
    endfunction

    function automatic void restart_frame();
        for (int l = 0; l < MAX_SIDE; l++)
            held_left[l] = '0;
        for (int l = 0; l <= MAX_SIDE; l++) begin
            col_cnt[l] = 0;
            row_cnt[l] = 0;
        end
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_SIZE_LOG2) begin
            cur_size = (val > 4'(MAX_SIDE)) ? MAX_SIDE : 32'(val);
            restart_frame();
        end else if (idx == REG_MIP_MODE) begin
            cur_mode = val[MODE_W-1:0];
            restart_frame();
        end
    endfunction

    // walk one pixel up the levels, collecting every finished 2x2 block
    function automatic void box_filter_cascade(input pix_t px, ref mip_pixel_t made[$]);
        quad_t       lanes;
        quad_t       pair;
        quad_t       total;
        int unsigned side;
        int unsigned col;
        int unsigned row;
        int unsigned idx;
        int unsigned full;
        mip_pixel_t  r;
        if (cur_mode == MODE_NONE)
            return;
        for (int k = 0; k < LANES; k++)
            lanes[k] = {2'b00, px[k]};
        full = 1 << cur_size;
        for (int unsigned lvl = 0; lvl < cur_size; lvl++) begin
            side = 1 << (cur_size - lvl);
            col  = col_cnt[lvl] & (side - 1);
            row  = row_cnt[lvl] & (side - 1);
            if (col + 1 == side) begin
                col_cnt[lvl] = 0;
                row_cnt[lvl] = (row + 1) & (side - 1);
            end else begin
                col_cnt[lvl] = col + 1;
                row_cnt[lvl] = row;
            end
            if ((col & 1) == 0) begin
                held_left[lvl] = lanes;
                break;
            end
            pair = lane_sum(held_left[lvl], lanes);
            idx  = full - (full >> lvl) + (col >> 1);
            if (idx >= PAIR_ROWS)
                break;
            if ((row & 1) == 0) begin
                pair_row[idx] = pair;
                break;
            end
            total = lane_sum(pair_row[idx], pair);
            for (int k = 0; k < LANES; k++)
                lanes[k] = (cur_mode == MODE_SUM) ? {2'b00, total[k][7:0]}
                                                  : {2'b00, total[k][9:2]};
            r.level = LEVEL_W'(lvl + 1);
            r.col   = POS_W'(col >> 1);
            r.row   = POS_W'(row >> 1);
            for (int k = 0; k < LANES; k++)
                r.pix[k] = lanes[k][CH_W-1:0];
            r.last  = 1'b0;
            made.push_back(r);
        end
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        m_word_t    got;
        mip_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (owed_mips.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                want = owed_mips.pop_front();
                check_field("level", 32'(want.level), 32'(got.level));
                check_field("col", 32'(want.col), 32'(got.col));
                check_field("row", 32'(want.row), 32'(got.row));
                check_field("out_red", 32'(want.pix[0]), 32'(got.red));
                check_field("out_green", 32'(want.pix[1]), 32'(got.green));
                check_field("out_blue", 32'(want.pix[2]), 32'(got.blue));
                check_field("out_alpha", 32'(want.pix[3]), 32'(got.alpha));
                check_field("last_of_run", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    task automatic send_pixel(input pix_t px, input logic typed, input mip_pixel_t want);
        mip_pixel_t made[$];
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        box_filter_cascade(px, made);
        if (typed)
            owed_mips.push_back(want);
        else
            foreach (made[i])
                owed_mips.push_back(made[i]);
    endtask

    task automatic wait_owed_empty();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_mips.size() != 0);
    endtask

    task automatic settle();
        wait_owed_empty();
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_write(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        step_t       steps [23];
        int          n_pix;
        int          frame;
        logic [3:0]  size_val;
        int          idle_tab [4];
        int          stall_tab [4];

        idle_tab  = '{0, 45, 0, 21};
        stall_tab = '{0, 0, 45, 21};
        steps = '{
            '{DO_WRITE, REG_SIZE_LOG2, 4'd1, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b1,
              '{4'd1, 10'd0, 10'd0, 32'hFFFFFFFF, 1'b1}},
            '{DO_WRITE, REG_MIP_MODE, {2'b10, MODE_SUM}, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b1,
              '{4'd1, 10'd0, 10'd0, 32'hFCFCFCFC, 1'b1}},
            '{DO_WRITE, REG_MIP_MODE, {2'b01, MODE_AVG_ALT}, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'h04030201, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'h80706050, 1'b0, '0},
            // dropped write, frame must carry on
            '{DO_WRITE, REG_SPARE_2, 4'd15, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'h01FF00FE, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'h7F7F8081, 1'b0, '0},
            '{DO_WRITE, REG_MIP_MODE, {2'b00, MODE_NONE}, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hFFFFFFFF, 1'b0, '0},
            '{DO_WRITE, REG_SIZE_LOG2, 4'd0, 32'h0, 1'b0, '0},
            '{DO_WRITE, REG_MIP_MODE, {2'b00, MODE_AVG}, 32'h0, 1'b0, '0},
            '{DO_PIXEL, REG_SIZE_LOG2, 4'd0, 32'hA5A5A5A5, 1'b0, '0},
            '{DO_WRITE, REG_SPARE_3, 4'd0, 32'h0, 1'b0, '0},
            // saturates to the largest side
            '{DO_WRITE, REG_SIZE_LOG2, 4'd15, 32'h0, 1'b0, '0}
        };

        cur_size = 32'(SIZE_LOG2_RST);
        cur_mode = MIP_MODE_RST;
        for (int i = 0; i < PAIR_ROWS; i++)
            pair_row[i] = '0;
        restart_frame();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a few pixels of the 256 side, none completes a block
        for (int i = 0; i < 4; i++)
            send_pixel(pix_t'($urandom()), 1'b0, '0);

        foreach (steps[i]) begin
            if (steps[i].kind == DO_WRITE) begin
                settle();
                write_reg(steps[i].reg_idx, steps[i].reg_val);
            end else begin
                send_pixel(steps[i].pix, steps[i].typed, steps[i].want);
            end
        end

        // a few pixels of the largest image
        for (int i = 0; i < 4; i++)
            send_pixel(pix_t'($urandom()), 1'b0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            idle_pct  = idle_tab[phase];
            stall_pct <= stall_tab[phase];
            size_val  = (phase == 0) ? 4'd3 : 4'($urandom_range(1, 2));
            write_reg(REG_SIZE_LOG2, size_val);
            write_reg(REG_MIP_MODE, {2'($urandom()), 2'($urandom_range(1, 3))});
            if (phase == 0)
                hold_toggle <= ~hold_toggle;
            frame = 1 << (2 * size_val);
            // a full frame under hold-off fills the queue past the admit mark
            if (phase == 0)
                n_pix = frame + $urandom_range(1, 4);
            else
                n_pix = frame + $urandom_range(0, frame / 2);
            for (int i = 0; i < n_pix; i++) begin
                if (phase == 2 && i == frame / 2)
                    wait_owed_empty();
                send_pixel(pix_t'($urandom()), 1'b0, '0);
            end
        end

        settle();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
